// File: src/srdm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sampled reuse distance monitor.
// Used by srdm_cell and by the top level; depends on nothing else.
package srdm_pkg;

  // Widths of the fixed item fields.
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned TID_W   = 4;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned LIFE_W  = 32;
  localparam int unsigned DIST_W  = 7;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDAT_W  = 16;

  // Input commands.
  localparam logic [CMD_W-1:0] CMD_ACCESS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DRAIN  = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_ENABLE      = 2'd0;
  localparam logic [CIDX_W-1:0] REG_THREAD_MASK = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BLOCK_SHIFT = 2'd2;

  localparam logic [SHIFT_W-1:0] BLOCK_SHIFT_RST = 4'd6;

  // Selection rule applied by every cell on the min chain.
  typedef enum logic [1:0] {
    SCAN_HIT,   // valid slot holding the accessed block
    SCAN_COLD,  // valid slot over the distance limit
    SCAN_ALL,   // every valid slot
    SCAN_FREE   // lowest-index empty slot
  } scan_mode_t;

  // Broadcast from the sequencer to all cells.
  typedef struct packed {
    logic              upd_start;
    logic              do_clear;
    logic              do_alloc;
    scan_mode_t        mode;
    logic [ADDR_W-1:0] blk;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_READ,
    CELL_CMP
  } cell_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_UPD,
    ST_UPD_WAIT,
    ST_FINAL
  } top_state_t;

  typedef enum logic [2:0] {
    PH_HIT_ACC,
    PH_HIT_SMP,
    PH_ALLOC,
    PH_COLD,
    PH_DRAIN
  } phase_t;

endpackage

// File: src/srdm_cell.sv
`timescale 1ns / 1ps
// One tracking slot: sampled block, lifetime, distinct count and its seen-block store,
// plus one stage of the registered selection chain. Depends on srdm_pkg.
module srdm_cell #(
  parameter int SLOTS        = 8,
  parameter int MAX_DISTANCE = 64,
  parameter int CELL_ID      = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  srdm_pkg::cell_cmd_t            cmd,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] target_id,
  input  logic                           in_v,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] in_id,
  input  logic [srdm_pkg::ADDR_W-1:0]    in_block,
  input  logic [srdm_pkg::LIFE_W-1:0]    in_life,
  input  logic [$clog2(MAX_DISTANCE+2)-1:0] in_count,
  output logic                           out_v,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] out_id,
  output logic [srdm_pkg::ADDR_W-1:0]    out_block,
  output logic [srdm_pkg::LIFE_W-1:0]    out_life,
  output logic [$clog2(MAX_DISTANCE+2)-1:0] out_count,
  output logic                           slot_on,
  output logic                           busy
);

  localparam int IW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SEEN_DEPTH = MAX_DISTANCE + 1;
  localparam int AW         = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
  localparam int CW         = $clog2(MAX_DISTANCE + 2);

  logic                        valid;
  logic [srdm_pkg::ADDR_W-1:0] block;
  logic [srdm_pkg::LIFE_W-1:0] life;
  logic [CW-1:0]               count;
  logic [AW-1:0]               idx;
  logic [srdm_pkg::ADDR_W-1:0] rd_data;
  logic [srdm_pkg::ADDR_W-1:0] seen_mem [SEEN_DEPTH];

  srdm_pkg::cell_state_t state, state_next;

  logic mine;
  logic start;
  logic last_entry;
  logic rd_hit;
  logic app_en;
  logic flag;
  logic take_own;

  assign mine       = (target_id == IW'(CELL_ID));
  assign start      = cmd.upd_start && valid;
  assign last_entry = ((CW'(idx) + CW'(1)) == count);
  assign rd_hit     = (rd_data == cmd.blk);

  // Next state of the seen-store search.
  always_comb begin
    state_next = state;
    unique case (state)
      srdm_pkg::CELL_IDLE: begin
        if (start && (count != '0)) state_next = srdm_pkg::CELL_READ;
      end
      srdm_pkg::CELL_READ: state_next = srdm_pkg::CELL_CMP;
      srdm_pkg::CELL_CMP: begin
        if (rd_hit || last_entry) state_next = srdm_pkg::CELL_IDLE;
        else state_next = srdm_pkg::CELL_READ;
      end
      default: state_next = srdm_pkg::CELL_IDLE;
    endcase
  end

  // Search outputs: append a block that was not found.
  always_comb begin
    app_en = 1'b0;
    busy   = (state != srdm_pkg::CELL_IDLE);
    unique case (state)
      srdm_pkg::CELL_IDLE: app_en = start && (count == '0);
      srdm_pkg::CELL_CMP:  app_en = !rd_hit && last_entry && (32'(count) < SEEN_DEPTH);
      default:             app_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srdm_pkg::CELL_IDLE;
      valid <= 1'b0;
      life  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      if (cmd.do_clear && mine) valid <= 1'b0;
      if (cmd.do_alloc && mine) begin
        valid <= 1'b1;
        life  <= '0;
        count <= '0;
      end
      if (start && (life != '1)) life <= life + 1'b1;
      if (app_en) count <= count + 1'b1;
    end
  end

  // Sampled block and search index carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.do_alloc && mine) block <= cmd.blk;
    if (state == srdm_pkg::CELL_IDLE) idx <= '0;
    else if (state == srdm_pkg::CELL_CMP) idx <= idx + 1'b1;
  end

  // Seen-block store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (app_en) seen_mem[count[AW-1:0]] <= cmd.blk;
    rd_data <= seen_mem[idx];
  end

  // Selection stage: keep the better of the upstream candidate and this slot.
  always_comb begin
    unique case (cmd.mode)
      srdm_pkg::SCAN_HIT:  flag = valid && (block == cmd.blk);
      srdm_pkg::SCAN_COLD: flag = valid && (count > CW'(MAX_DISTANCE));
      srdm_pkg::SCAN_ALL:  flag = valid;
      default:             flag = !valid;
    endcase
    if (cmd.mode == srdm_pkg::SCAN_FREE) take_own = flag && !in_v;
    else take_own = flag && (!in_v || (block < in_block));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v || take_own;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      out_id    <= IW'(CELL_ID);
      out_block <= block;
      out_life  <= life;
      out_count <= count;
    end else begin
      out_id    <= in_id;
      out_block <= in_block;
      out_life  <= in_life;
      out_count <= in_count;
    end
  end

  assign slot_on = valid;

`ifndef NO_ASSERTIONS
  // The distinct count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= SEEN_DEPTH)
    else $error("distinct count beyond store depth");

  // A search only runs on a tracked slot.
  a_search_valid: assert property (@(posedge clk) disable iff (rst)
    busy |-> valid)
    else $error("search on an empty slot");

  // A new sample never lands on a tracked slot.
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_alloc && mine) |-> !valid)
    else $error("allocation over a tracked slot");
`endif

endmodule

// File: src/sampled_reuse_distance_monitor_core.sv
`timescale 1ns / 1ps
// Top level of the sampled reuse distance monitor: sequencer, configuration,
// output register and the chain of srdm_cell slots. Depends on srdm_pkg and srdm_cell.

// Tracks up to SLOTS sampled blocks in a row of cells. Each cell runs its own
// seen-block search over its store, reading and then comparing each stored block,
// and all cells search in parallel. Retirements are chosen by a registered min
// chain through the cells, and each pick is a scan through the whole chain. An
// access scans for a reuse hit and retires it, starts the searches, then retires
// every slot over the distance limit. A new sample scans for its block and, when
// it is not already tracked, for a free slot. A drain retires every tracked slot,
// one word each. Output stalls can hold any of these. Results leave through one
// output register; the next item is taken after the final word of the current
// one is loaded. No clearing pass is needed after reset.
module sampled_reuse_distance_monitor_core #(
  parameter int SLOTS        = 8,
  parameter int MAX_DISTANCE = 64,
  parameter int THREADS      = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srdm_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [srdm_pkg::CDAT_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [srdm_pkg::CMD_W-1:0]     command,
  input  logic [srdm_pkg::ADDR_W-1:0]    access_address,
  input  logic [srdm_pkg::TID_W-1:0]     thread_id,
  input  logic [srdm_pkg::ADDR_W-1:0]    access_pc,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           has_sample,
  output logic [srdm_pkg::ADDR_W-1:0]    sample_block,
  output logic [srdm_pkg::ADDR_W-1:0]    reuse_pc,
  output logic [srdm_pkg::DIST_W-1:0]    distance,
  output logic                           cold,
  output logic [srdm_pkg::LIFE_W-1:0]    lifetime,
  output logic                           sample_dropped,
  output logic                           tracked_empty,
  output logic                           last
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(MAX_DISTANCE + 2);
  localparam int NW  = $clog2(SLOTS + 1);

  // Configuration registers.
  logic                          enable;
  logic [srdm_pkg::MASK_W-1:0]   thread_mask;
  logic [srdm_pkg::SHIFT_W-1:0]  block_shift;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      thread_mask <= '0;
      block_shift <= srdm_pkg::BLOCK_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srdm_pkg::REG_ENABLE:      enable      <= cfg_data[0];
        srdm_pkg::REG_THREAD_MASK: thread_mask <= cfg_data;
        srdm_pkg::REG_BLOCK_SHIFT: block_shift <= cfg_data[srdm_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers.
  srdm_pkg::top_state_t state, state_next;
  srdm_pkg::phase_t     phase;
  srdm_pkg::scan_mode_t mode;
  logic [NW-1:0]               cnt;
  logic [srdm_pkg::ADDR_W-1:0] blk;
  logic [srdm_pkg::ADDR_W-1:0] pc;
  logic                        dropped;

  // Chain wiring: stage 0 is an empty candidate.
  logic                        ch_v     [SLOTS+1];
  logic [IW-1:0]               ch_id    [SLOTS+1];
  logic [srdm_pkg::ADDR_W-1:0] ch_block [SLOTS+1];
  logic [srdm_pkg::LIFE_W-1:0] ch_life  [SLOTS+1];
  logic [CW-1:0]               ch_count [SLOTS+1];
  logic [SLOTS-1:0]            slot_on;
  logic [SLOTS-1:0]            cell_busy;

  srdm_pkg::cell_cmd_t cmd;

  logic in_take;
  logic out_free;
  logic scan_done;
  logic thread_on;
  logic tail_v;
  logic any_busy;
  logic [srdm_pkg::DIST_W-1:0] tail_dist;

  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign scan_done = (cnt == NW'(SLOTS));
  assign thread_on = enable && (32'(thread_id) < THREADS) && thread_mask[thread_id];
  assign tail_v    = ch_v[SLOTS];
  assign any_busy  = |cell_busy;

  assign ch_v[0]     = 1'b0;
  assign ch_id[0]    = '0;
  assign ch_block[0] = '0;
  assign ch_life[0]  = '0;
  assign ch_count[0] = '0;

  // Reported distance saturates at the field maximum.
  always_comb begin
    if (32'(ch_count[SLOTS]) > 32'd127) tail_dist = 7'd127;
    else tail_dist = srdm_pkg::DIST_W'(ch_count[SLOTS]);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      srdm_pkg::ST_IDLE: begin
        if (in_take) begin
          if (((command == srdm_pkg::CMD_ACCESS) || (command == srdm_pkg::CMD_SAMPLE))
              && thread_on) state_next = srdm_pkg::ST_SCAN;
          else if (command == srdm_pkg::CMD_DRAIN) state_next = srdm_pkg::ST_SCAN;
          else state_next = srdm_pkg::ST_FINAL;
        end
      end
      srdm_pkg::ST_SCAN: begin
        if (scan_done) begin
          unique case (phase)
            srdm_pkg::PH_HIT_ACC:
              state_next = tail_v ? srdm_pkg::ST_EMIT : srdm_pkg::ST_UPD;
            srdm_pkg::PH_HIT_SMP:
              state_next = tail_v ? srdm_pkg::ST_FINAL : srdm_pkg::ST_SCAN;
            srdm_pkg::PH_ALLOC:
              state_next = srdm_pkg::ST_FINAL;
            default:
              state_next = tail_v ? srdm_pkg::ST_EMIT : srdm_pkg::ST_FINAL;
          endcase
        end
      end
      srdm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (phase == srdm_pkg::PH_HIT_ACC) ? srdm_pkg::ST_UPD : srdm_pkg::ST_SCAN;
        end
      end
      srdm_pkg::ST_UPD: state_next = srdm_pkg::ST_UPD_WAIT;
      srdm_pkg::ST_UPD_WAIT: begin
        if (!any_busy) state_next = srdm_pkg::ST_SCAN;
      end
      srdm_pkg::ST_FINAL: begin
        if (out_free) state_next = srdm_pkg::ST_IDLE;
      end
      default: state_next = srdm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer toward the port and the cells.
  always_comb begin
    in_stall      = (state != srdm_pkg::ST_IDLE);
    cmd.upd_start = (state == srdm_pkg::ST_UPD);
    cmd.do_clear  = (state == srdm_pkg::ST_EMIT) && out_free;
    cmd.do_alloc  = (state == srdm_pkg::ST_SCAN) && scan_done &&
                    (phase == srdm_pkg::PH_ALLOC) && tail_v;
    cmd.mode      = mode;
    cmd.blk       = blk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srdm_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if ((state == srdm_pkg::ST_SCAN) && !scan_done) cnt <= cnt + 1'b1;
      else cnt <= '0;
    end
  end

  // Item context and scan phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= srdm_pkg::PH_HIT_ACC;
      mode    <= srdm_pkg::SCAN_HIT;
      dropped <= 1'b0;
    end else begin
      priority if (state == srdm_pkg::ST_IDLE && in_take) begin
        dropped <= 1'b0;
        if (command == srdm_pkg::CMD_DRAIN) begin
          phase <= srdm_pkg::PH_DRAIN;
          mode  <= srdm_pkg::SCAN_ALL;
        end else if (command == srdm_pkg::CMD_SAMPLE) begin
          phase <= srdm_pkg::PH_HIT_SMP;
          mode  <= srdm_pkg::SCAN_HIT;
        end else begin
          phase <= srdm_pkg::PH_HIT_ACC;
          mode  <= srdm_pkg::SCAN_HIT;
        end
      end else if (state == srdm_pkg::ST_SCAN && scan_done && !tail_v &&
                   phase == srdm_pkg::PH_HIT_SMP) begin
        phase <= srdm_pkg::PH_ALLOC;
        mode  <= srdm_pkg::SCAN_FREE;
      end else if (state == srdm_pkg::ST_SCAN && scan_done && !tail_v &&
                   phase == srdm_pkg::PH_ALLOC) begin
        dropped <= 1'b1;
      end else if (state == srdm_pkg::ST_UPD_WAIT && !any_busy) begin
        phase <= srdm_pkg::PH_COLD;
        mode  <= srdm_pkg::SCAN_COLD;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == srdm_pkg::ST_IDLE && in_take) begin
      blk <= access_address >> block_shift;
      pc  <= access_pc;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == srdm_pkg::ST_EMIT || state == srdm_pkg::ST_FINAL) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srdm_pkg::ST_EMIT && out_free) begin
      has_sample     <= 1'b1;
      sample_block   <= ch_block[SLOTS];
      reuse_pc       <= (phase == srdm_pkg::PH_DRAIN) ? '0 : pc;
      distance       <= tail_dist;
      cold           <= (phase != srdm_pkg::PH_HIT_ACC);
      lifetime       <= ch_life[SLOTS];
      sample_dropped <= 1'b0;
      tracked_empty  <= 1'b0;
      last           <= 1'b0;
    end else if (state == srdm_pkg::ST_FINAL && out_free) begin
      has_sample     <= 1'b0;
      sample_block   <= '0;
      reuse_pc       <= '0;
      distance       <= '0;
      cold           <= 1'b0;
      lifetime       <= '0;
      sample_dropped <= dropped;
      tracked_empty  <= ~|slot_on;
      last           <= 1'b1;
    end
  end

  // Row of slot cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    srdm_cell #(
      .SLOTS        (SLOTS),
      .MAX_DISTANCE (MAX_DISTANCE),
      .CELL_ID      (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .target_id (ch_id[SLOTS]),
      .in_v      (ch_v[i]),
      .in_id     (ch_id[i]),
      .in_block  (ch_block[i]),
      .in_life   (ch_life[i]),
      .in_count  (ch_count[i]),
      .out_v     (ch_v[i+1]),
      .out_id    (ch_id[i+1]),
      .out_block (ch_block[i+1]),
      .out_life  (ch_life[i+1]),
      .out_count (ch_count[i+1]),
      .slot_on   (slot_on[i]),
      .busy      (cell_busy[i])
    );
  end

`ifndef NO_ASSERTIONS
  // A retirement word never closes an item.
  a_word_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(has_sample && last))
    else $error("retirement word marked last");

  // Cell searches run only while the sequencer waits for them.
  a_busy_window: assert property (@(posedge clk) disable iff (rst)
    any_busy |-> (state == srdm_pkg::ST_UPD_WAIT))
    else $error("cell search outside update window");

  // A new item is taken only with all searches finished.
  a_take_quiet: assert property (@(posedge clk) disable iff (rst)
    in_take |-> !any_busy)
    else $error("item taken during a search");
`endif

endmodule
